[design/spg_pkg.sv]
// Package for the servo pulse generator.
// Holds the beat types, the function codes and the fixed constants.
// It depends on nothing else.
package spg_pkg;

	// Number of pin bits in a result beat.
	localparam int unsigned PIN_W = 6;

	// Frame slots between two servo channels.
	localparam int unsigned SLOT_SPACING = 3;

	// Register reset values.
	localparam logic [7:0] PERIOD_TOP_RESET = 8'd249;
	localparam logic [5:0] CHAN_EN_RESET = 6'h3F;
	localparam logic [7:0] COMPARE_RESET = 8'd124;

	// Position band limits.
	localparam logic [7:0] BAND_LOW_END = 8'd64;
	localparam logic [7:0] BAND_MID_END = 8'd192;

	// Configuration register indexes.
	localparam logic REG_PERIOD_TOP = 1'b0;
	localparam logic REG_CHANNEL_ENABLE = 1'b1;

	// Item function codes.
	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	// Input beat.
	typedef struct packed {
		func_t      func;
		logic [2:0] servo_index;
		logic [7:0] servo_value;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [PIN_W-1:0] pin_levels;
		logic [31:0]      elapsed_ms;
		logic [7:0]       read_value;
	} result_t;

	// Slot lookup from the position store to the timer.
	typedef struct packed {
		logic             hit;
		logic [PIN_W-1:0] pin_mask;
		logic [7:0]       compare;
		logic [1:0]       count;
	} slot_t;

endpackage

[design/spg_scale.sv]
// Position scaler: maps a raw 0..255 position to a compare value and a
// whole-millisecond count in three bands. Uses spg_pkg constants.
module spg_scale (
	input  logic [7:0] period_top,
	input  logic [7:0] servo_value,
	output logic [7:0] compare,
	output logic [1:0] count
);

	logic [6:0]  half;
	logic [12:0] prod_edge;
	logic [7:0]  mid_offset;
	logic [14:0] prod_mid;

	// The low and high bands both scale the low six bits by half the period.
	assign half = period_top[7:1];
	assign prod_edge = 13'(servo_value[5:0]) * 13'(half);
	assign mid_offset = servo_value - spg_pkg::BAND_LOW_END;
	assign prod_mid = 15'(mid_offset[6:0]) * 15'(period_top);

	// Band selection.
	always_comb begin
		if (servo_value < spg_pkg::BAND_LOW_END) begin
			count = 2'd0;
			compare = 8'(prod_edge[12:6]) + 8'(half);
		end else if (servo_value < spg_pkg::BAND_MID_END) begin
			count = 2'd1;
			compare = prod_mid[14:7];
		end else begin
			count = 2'd2;
			compare = 8'(prod_edge[12:6]);
		end
	end

endmodule

[design/spg_store.sv]
// Per-channel position store: raw positions, scaled compares and counts.
// Uses spg_pkg types and spg_scale for the position scaling.
module spg_store #(
	parameter int unsigned NUM_CHANNELS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      set_en,
	input  logic [2:0]                servo_index,
	input  logic [7:0]                servo_value,
	input  logic [7:0]                period_top,
	input  logic [5:0]                channel_enable,
	input  logic [4:0]                frame_index,
	output logic [7:0]                read_value,
	output spg_pkg::slot_t            slot
);

	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [7:0]       raw_q [NUM_CHANNELS];
	logic [7:0]       cmp_q [NUM_CHANNELS];
	logic [1:0]       cnt_q [NUM_CHANNELS];
	logic [7:0]       new_compare;
	logic [1:0]       new_count;
	logic             in_range;
	logic [IDX_W-1:0] idx;

	spg_scale u_scale (
		.period_top  (period_top),
		.servo_value (servo_value),
		.compare     (new_compare),
		.count       (new_count)
	);

	assign in_range = servo_index < 3'(NUM_CHANNELS);
	assign idx = servo_index[IDX_W-1:0];

	// A set stores even for a disabled channel; out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				raw_q[k] <= '0;
				cmp_q[k] <= spg_pkg::COMPARE_RESET;
				cnt_q[k] <= '0;
			end
		end else if (set_en && in_range) begin
			raw_q[idx] <= servo_value;
			cmp_q[idx] <= new_compare;
			cnt_q[idx] <= new_count;
		end
	end

	// Read-back is zero for a disabled or nonexistent channel.
	assign read_value = (in_range && channel_enable[servo_index]) ? raw_q[idx] : '0;

	// Find the enabled channel that owns the current frame slot.
	always_comb begin
		slot = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (frame_index == 5'(k * spg_pkg::SLOT_SPACING) && channel_enable[k]) begin
				slot.hit = 1'b1;
				slot.pin_mask = spg_pkg::PIN_W'(1) << k;
				slot.compare = cmp_q[k];
				slot.count = cnt_q[k];
			end
		end
	end

endmodule

[design/spg_timer.sv]
// Millisecond timer, frame counter and pin compare logic.
// Uses spg_pkg types; the slot lookup comes from spg_store.
module spg_timer #(
	parameter int unsigned FRAMES_PER_PERIOD = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_en,
	input  logic [7:0]                 period_top,
	input  spg_pkg::slot_t             slot,
	output logic [4:0]                 frame_index,
	output logic [spg_pkg::PIN_W-1:0]  pin_d,
	output logic [31:0]                ms_d
);

	logic [7:0]  sub_q, sub_d;
	logic [4:0]  frame_q, frame_d;
	logic [7:0]  loops_q, loops_d;
	logic [7:0]  acmp_q, acmp_d;
	logic        armed_q, armed_d;
	logic [spg_pkg::PIN_W-1:0] pin_q;
	logic [31:0] ms_q;
	logic        wrap;
	logic [5:0]  frame_inc;

	assign wrap = sub_q == period_top;
	assign frame_inc = {1'b0, frame_q} + 6'd1;
	assign frame_index = frame_q;

	// Next-state logic for one timer tick.
	always_comb begin
		sub_d = sub_q;
		frame_d = frame_q;
		loops_d = loops_q;
		acmp_d = acmp_q;
		armed_d = armed_q;
		pin_d = pin_q;
		ms_d = ms_q;
		if (tick_en) begin
			sub_d = wrap ? '0 : sub_q + 8'd1;
			if (wrap) begin
				if (slot.hit) begin
					acmp_d = slot.compare;
					loops_d = {6'd0, slot.count};
					pin_d = pin_q | slot.pin_mask;
				end
				// The count has run out: either end the pulse now or arm the compare.
				if (loops_d == '0) begin
					if (acmp_d == '0) begin
						pin_d = '0;
						armed_d = 1'b0;
					end else begin
						armed_d = 1'b1;
					end
				end
				loops_d = loops_d - 8'd1;
				frame_d = (frame_inc >= 6'(FRAMES_PER_PERIOD)) ? '0 : frame_inc[4:0];
				ms_d = ms_q + 32'd1;
			end
			// A compare match while armed ends the pulse.
			if (armed_d && sub_d == acmp_d) begin
				pin_d = '0;
				armed_d = 1'b0;
			end
		end
	end

	// Timer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			frame_q <= '0;
			loops_q <= '0;
			acmp_q <= '0;
			armed_q <= 1'b0;
			pin_q <= '0;
			ms_q <= '0;
		end else begin
			sub_q <= sub_d;
			frame_q <= frame_d;
			loops_q <= loops_d;
			acmp_q <= acmp_d;
			armed_q <= armed_d;
			pin_q <= pin_d;
			ms_q <= ms_d;
		end
	end

	// The frame counter stays inside the frame.
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, frame_q} < 6'(FRAMES_PER_PERIOD))
		else $error("frame index out of range");

	// The millisecond count moves only on a tick.
	a_ms_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_en |=> $stable(ms_q))
		else $error("millisecond count changed without a tick");

	// A wrap adds exactly one millisecond.
	a_ms_step: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && wrap |=> ms_q == $past(ms_q) + 32'd1)
		else $error("millisecond count did not step on wrap");

endmodule

[design/servo_pulse_generator_top.sv]
// Servo pulse generator top level: input stage, result register, config.
// An accepted item beat goes through the input stage register, then the result register.
// Throughput: one item per cycle while result_stall is low; the whole update is one pass
// of logic between the input stage register and the result register.
// Reset: arst_n clears the timer, pins, stored positions and both stages;
// period_top returns to 249, channel_enable to all ones, compares to 124.
// Depends on spg_pkg, spg_store and spg_timer.
module servo_pulse_generator_top #(
	parameter int unsigned NUM_CHANNELS = 6,
	parameter int unsigned FRAMES_PER_PERIOD = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  spg_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output spg_pkg::result_t  result
);

	logic             valid_s1;
	spg_pkg::item_t   item_s1;
	logic [7:0]       period_top_q;
	logic [5:0]       channel_enable_q;
	logic             advance;
	logic             move;
	logic             tick_en;
	logic             set_en;
	logic             is_read;
	logic [7:0]       read_raw;
	logic [4:0]       frame_index;
	spg_pkg::slot_t   slot;
	logic [spg_pkg::PIN_W-1:0] pin_d;
	logic [31:0]      ms_d;

	// The stage moves forward when the result register is free or being taken.
	assign advance = !result_valid || !result_stall;
	assign move = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Decode the function of the item in the stage.
	always_comb begin
		tick_en = 1'b0;
		set_en = 1'b0;
		is_read = 1'b0;
		unique case (item_s1.func)
			spg_pkg::FUNC_TICK: tick_en = move;
			spg_pkg::FUNC_SET:  set_en = move;
			spg_pkg::FUNC_READ: is_read = 1'b1;
			default: ;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= spg_pkg::PERIOD_TOP_RESET;
			channel_enable_q <= spg_pkg::CHAN_EN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spg_pkg::REG_PERIOD_TOP:     period_top_q <= cfg_data;
				spg_pkg::REG_CHANNEL_ENABLE: channel_enable_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	spg_store #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.set_en         (set_en),
		.servo_index    (item_s1.servo_index),
		.servo_value    (item_s1.servo_value),
		.period_top     (period_top_q),
		.channel_enable (channel_enable_q),
		.frame_index    (frame_index),
		.read_value     (read_raw),
		.slot           (slot)
	);

	spg_timer #(
		.FRAMES_PER_PERIOD (FRAMES_PER_PERIOD)
	) u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_en     (tick_en),
		.period_top  (period_top_q),
		.slot        (slot),
		.frame_index (frame_index),
		.pin_d       (pin_d),
		.ms_d        (ms_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (move) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			result.pin_levels <= pin_d;
			result.elapsed_ms <= ms_d;
			result.read_value <= is_read ? read_raw : '0;
		end
	end

	// Input stalls only while an item waits in the stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without a blocked result");

	// A result beat leaves only when it is taken.
	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result beat dropped while stalled");

	// An item that moves always shows up as a result.
	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> result_valid)
		else $error("moved item produced no result");

endmodule

[test/servo_pulse_generator_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for servo_pulse_generator_top: directed table, then random phases.
// Each result beat is checked against a predictor of the timer and position store, or against its typed table row.
// Depends on spg_pkg and the servo_pulse_generator_top RTL.
module servo_pulse_generator_top_tb;

	localparam int unsigned SERVO_COUNT = 6;
	localparam int unsigned FRAME_SLOTS = 20;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = spg_pkg::REG_PERIOD_TOP;
	logic [7:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	spg_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	spg_pkg::result_t result;

	// Random idling is turned off for whole phases, and the long hold-off is requested once.
	logic quiet_phase = 1'b0;
	logic hold_off_req = 1'b0;

	spg_pkg::result_t pending_beats[$];
	int unsigned mismatches = 0;
	int unsigned beats_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned settings_used = 1;
	int unsigned quiet_cycles = 0;

	// Predicted registers and state of the block.
	logic [7:0] top_q;
	logic [5:0] enable_q;
	logic [7:0] sub_ms_q;
	logic [4:0] slot_q;
	logic [7:0] loops_q;
	logic [7:0] compare_q;
	logic armed_q;
	logic [5:0] pins_q;
	logic [31:0] ms_q;
	logic [7:0] raw_pos[SERVO_COUNT];
	logic [7:0] compare_store[SERVO_COUNT];
	logic [1:0] whole_ms_store[SERVO_COUNT];
	int unsigned wraps_seen = 0;
	int unsigned rises_seen = 0;
	int unsigned clears_seen = 0;

	// Directed stimulus; rows marked typed carry the read value that must come back
	// with pins and milliseconds still zero.
	typedef struct packed {
		logic [1:0] code;
		logic [2:0] index;
		logic [7:0] value;
		logic       typed;
		logic [7:0] want_read;
	} dir_row_t;

	dir_row_t directed_rows[19] = '{
		'{spg_pkg::FUNC_READ, 3'd0, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd5, 8'd255, 1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd0, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd0, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd1, 8'd255, 1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd1, 8'd0,   1'b1, 8'd255},
		'{spg_pkg::FUNC_SET,  3'd2, 8'd63,  1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd3, 8'd64,  1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd4, 8'd191, 1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd5, 8'd192, 1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd5, 8'd0,   1'b1, 8'd192},
		'{spg_pkg::FUNC_READ, 3'd6, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd7, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd6, 8'd170, 1'b1, 8'd0},
		'{spg_pkg::FUNC_SET,  3'd7, 8'd85,  1'b1, 8'd0},
		'{FUNC_UNUSED,        3'd0, 8'd255, 1'b1, 8'd0},
		'{spg_pkg::FUNC_READ, 3'd4, 8'd0,   1'b1, 8'd191},
		'{spg_pkg::FUNC_TICK, 3'd0, 8'd0,   1'b1, 8'd0},
		'{spg_pkg::FUNC_TICK, 3'd7, 8'd255, 1'b0, 8'd0}
	};

	servo_pulse_generator_top #(
		.NUM_CHANNELS(SERVO_COUNT),
		.FRAMES_PER_PERIOD(FRAME_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor state after reset.
	function automatic void clear_servo_state();
		top_q = spg_pkg::PERIOD_TOP_RESET;
		enable_q = spg_pkg::CHAN_EN_RESET;
		sub_ms_q = '0;
		slot_q = '0;
		loops_q = '0;
		compare_q = '0;
		armed_q = 1'b0;
		pins_q = '0;
		ms_q = '0;
		for (int k = 0; k < SERVO_COUNT; k++) begin
			raw_pos[k] = '0;
			compare_store[k] = spg_pkg::COMPARE_RESET;
			whole_ms_store[k] = '0;
		end
	endfunction

	function automatic void drop_pins();
		if (pins_q != '0)
			clears_seen++;
		pins_q = '0;
		armed_q = 1'b0;
	endfunction

	// One millisecond boundary: slot owner raises its pin and loads its pulse length.
	function automatic void roll_millisecond();
		int k;
		for (k = 0; k < SERVO_COUNT; k++) begin
			if (int'(slot_q) == k * spg_pkg::SLOT_SPACING && enable_q[k]) begin
				compare_q = compare_store[k];
				loops_q = {6'd0, whole_ms_store[k]};
				pins_q[k] = 1'b1;
				rises_seen++;
			end
		end
		if (loops_q == '0) begin
			if (compare_q == '0)
				drop_pins();
			else
				armed_q = 1'b1;
		end
		loops_q = loops_q - 8'd1;
		if (int'(slot_q) + 1 >= FRAME_SLOTS)
			slot_q = '0;
		else
			slot_q = slot_q + 5'd1;
		ms_q = ms_q + 32'd1;
		wraps_seen++;
	endfunction

	function automatic void advance_timer();
		if (sub_ms_q == top_q) begin
			sub_ms_q = '0;
			roll_millisecond();
		end else begin
			sub_ms_q = sub_ms_q + 8'd1;
		end
		if (armed_q && sub_ms_q == compare_q)
			drop_pins();
	endfunction

	// Scale a 0..255 position into whole milliseconds plus a compare value.
	function automatic void store_position(input logic [2:0] idx, input logic [7:0] value);
		int unsigned v;
		int unsigned top;
		int unsigned half;
		int unsigned scaled;
		if (idx >= SERVO_COUNT)
			return;
		v = value;
		top = top_q;
		half = top >> 1;
		raw_pos[idx] = value;
		if (v < spg_pkg::BAND_LOW_END) begin
			whole_ms_store[idx] = 2'd0;
			scaled = ((v * half) >> 6) + half;
		end else if (v < spg_pkg::BAND_MID_END) begin
			whole_ms_store[idx] = 2'd1;
			scaled = ((v - spg_pkg::BAND_LOW_END) * top) >> 7;
		end else begin
			whole_ms_store[idx] = 2'd2;
			scaled = ((v - spg_pkg::BAND_MID_END) * half) >> 6;
		end
		compare_store[idx] = scaled[7:0];
	endfunction

	function automatic spg_pkg::result_t predict_servo_beat(input spg_pkg::item_t b);
		spg_pkg::result_t r;
		logic [7:0] readback;
		readback = '0;
		case (b.func)
			spg_pkg::FUNC_TICK: advance_timer();
			spg_pkg::FUNC_SET: store_position(b.servo_index, b.servo_value);
			spg_pkg::FUNC_READ: begin
				if (b.servo_index < SERVO_COUNT) begin
					if (enable_q[b.servo_index])
						readback = raw_pos[b.servo_index];
				end
			end
			default: ;
		endcase
		r.pin_levels = pins_q;
		r.elapsed_ms = ms_q;
		r.read_value = readback;
		return r;
	endfunction

	// Idle lengths: mostly short, now and then long.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Random item: mostly ticks so that frames run, with sets, reads and odd cases mixed in.
	function automatic spg_pkg::item_t random_beat();
		spg_pkg::item_t b;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		b.servo_index = 3'($urandom_range(0, 5));
		b.servo_value = 8'($urandom_range(0, 255));
		if (pick < 68) begin
			b.func = spg_pkg::FUNC_TICK;
			if (pick[1])
				b.servo_index = 3'($urandom_range(0, 7));
		end else if (pick < 82) begin
			b.func = spg_pkg::FUNC_SET;
		end else if (pick < 94) begin
			b.func = spg_pkg::FUNC_READ;
		end else if (pick < 97) begin
			b.func = pick[0] ? spg_pkg::FUNC_SET : spg_pkg::FUNC_READ;
			b.servo_index = 3'($urandom_range(6, 7));
		end else begin
			b.func = spg_pkg::func_t'(FUNC_UNUSED);
		end
		return b;
	endfunction

	task automatic check_beat(input spg_pkg::result_t got);
		spg_pkg::result_t want;
		if (pending_beats.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with nothing expected: pins %h ms %0d read %0d",
				$time, got.pin_levels, got.elapsed_ms, got.read_value);
			return;
		end
		want = pending_beats.pop_front();
		beats_checked++;
		if (got.pin_levels !== want.pin_levels) begin
			mismatches++;
			$display("%0t: pin_levels expected %h actual %h",
				$time, want.pin_levels, got.pin_levels);
		end
		if (got.elapsed_ms !== want.elapsed_ms) begin
			mismatches++;
			$display("%0t: elapsed_ms expected %0d actual %0d",
				$time, want.elapsed_ms, got.elapsed_ms);
		end
		if (got.read_value !== want.read_value) begin
			mismatches++;
			$display("%0t: read_value expected %0d actual %0d",
				$time, want.read_value, got.read_value);
		end
	endtask

	// Offer one beat, hold it until accepted, then maybe leave a gap.
	task automatic send_beat(input spg_pkg::item_t b, input logic typed,
			input logic [7:0] want_read);
		spg_pkg::result_t predicted;
		int unsigned gap;
		item <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = predict_servo_beat(b);
		if (typed)
			pending_beats.push_back('{pin_levels: '0, elapsed_ms: '0, read_value: want_read});
		else
			pending_beats.push_back(predicted);
		beats_sent++;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = idle_length();
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers are written one after the other while the block is idle.
	task automatic write_config(input logic [7:0] top, input logic [5:0] enable);
		cfg_we <= 1'b1;
		cfg_index <= spg_pkg::REG_PERIOD_TOP;
		cfg_data <= top;
		@(posedge clk);
		cfg_index <= spg_pkg::REG_CHANNEL_ENABLE;
		cfg_data <= {2'b00, enable};
		@(posedge clk);
		cfg_we <= 1'b0;
		top_q = top;
		enable_q = enable;
		settings_used++;
	endtask

	task automatic run_phase(input logic [7:0] top, input logic [5:0] enable,
			input int unsigned count, input logic quiet, input logic hold);
		wait_drained();
		write_config(top, enable);
		quiet_phase <= quiet;
		for (int unsigned i = 0; i < count; i++) begin
			if (hold && i == count / 4)
				hold_off_req <= 1'b1;
			send_beat(random_beat(), 1'b0, 8'd0);
		end
		item_valid <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_side
		int unsigned stall_left;
		logic hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				check_beat(result);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
				if (!quiet_phase && $urandom_range(0, 3) == 0)
					stall_left = idle_length();
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("servo_pulse_generator_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: reset, directed table at reset settings, then random phases.
	initial begin : item_side
		spg_pkg::item_t b;
		clear_servo_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			b.func = spg_pkg::func_t'(directed_rows[i].code);
			b.servo_index = directed_rows[i].index;
			b.servo_value = directed_rows[i].value;
			send_beat(b, directed_rows[i].typed, directed_rows[i].want_read);
		end
		item_valid <= 1'b0;

		run_phase(8'd1, 6'h3F, 160, 1'b0, 1'b1);
		run_phase(8'd255, 6'h3F, 150, 1'b0, 1'b0);
		run_phase(8'd2, 6'h15, 160, 1'b1, 1'b0);
		run_phase(8'd4, 6'h00, 120, 1'b0, 1'b0);
		run_phase(8'd3, 6'h2A, 160, 1'b0, 1'b0);
		run_phase(8'($urandom_range(1, 12)), 6'($urandom_range(0, 63)), 180, 1'b0, 1'b0);
		run_phase(8'($urandom_range(5, 40)), 6'h3F, 180, 1'b0, 1'b0);
		run_phase(8'd6, 6'h3F, 180, 1'b0, 1'b0);

		wait_drained();
		$display("Sent %0d item beats and checked %0d result beats under %0d settings.",
			beats_sent, beats_checked, settings_used);
		$display("Predicted %0d millisecond wraps, %0d pin rises and %0d pin clears.",
			wraps_seen, rises_seen, clears_seen);
		if (mismatches == 0)
			$display("servo_pulse_generator_top test passed");
		else
			$display("servo_pulse_generator_top test failed");
		$finish;
	end

endmodule

[filelist.f]
design/spg_pkg.sv
design/spg_scale.sv
design/spg_store.sv
design/spg_timer.sv
design/servo_pulse_generator_top.sv
test/servo_pulse_generator_top_tb.sv
